// File: rtl/indexed_priority_table_core_macros.svh
// Assertion macros for the indexed priority table core.
// Included by modules that carry concurrent assertions; needs clk and arst_n in scope.
`ifndef INDEXED_PRIORITY_TABLE_CORE_MACROS_SVH
`define INDEXED_PRIORITY_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define IPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// next-cycle implication
`define IPT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

// File: rtl/ipt_pkg.sv
// Shared types and codes for the indexed priority table core.
// No dependencies.
package ipt_pkg;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_PROMOTE  = 3'd1,
		CMD_IS_VALID = 3'd2,
		CMD_GET      = 3'd3,
		CMD_GET_MAX  = 3'd4,
		CMD_POP_MAX  = 3'd5
	} ipt_cmd_t;

	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_UNKNOWN   = 3'd1,
		STAT_EMPTY     = 3'd2,
		STAT_FULL      = 3'd3,
		STAT_EXHAUSTED = 3'd4
	} ipt_status_t;

	localparam logic [31:0] LAST_ID  = 32'hFFFF_FFFF;
	localparam logic [15:0] MAX_PRIO = 16'hFFFF;

	typedef struct packed {
		logic        vld;
		logic [31:0] id;
		logic [15:0] prio;
		logic [31:0] pay;
	} ipt_entry_t;

	localparam int ENTRY_W = $bits(ipt_entry_t);

	typedef struct packed {
		logic free;
		logic match;
		logic best;
	} ipt_found_t;

endpackage

// File: rtl/ipt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ipt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/ipt_scan.sv
// Scan accumulator: tracks first free slot, id match and highest (priority, id) entry.
// Depends on ipt_pkg.
module ipt_scan import ipt_pkg::*; #(
	parameter int AW = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        rvld_s1,
	input  logic [AW-1:0] raddr_s1,
	input  ipt_entry_t  rdata,
	input  logic [31:0] key,
	output ipt_found_t  found,
	output logic [AW-1:0] free_slot,
	output logic [AW-1:0] match_slot,
	output ipt_entry_t  match_entry,
	output logic [AW-1:0] best_slot,
	output ipt_entry_t  best_entry
);

	ipt_found_t found_q;
	logic [AW-1:0] free_slot_q, match_slot_q, best_slot_q;
	ipt_entry_t match_entry_q, best_entry_q;
	logic better;

	assign better = !found_q.best || (rdata.prio > best_entry_q.prio) ||
		((rdata.prio == best_entry_q.prio) && (rdata.id > best_entry_q.id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (start) begin
			found_q <= '0;
		end else if (rvld_s1) begin
			if (!rdata.vld && !found_q.free) begin
				found_q.free <= 1'b1;
			end
			if (rdata.vld && rdata.id == key) begin
				found_q.match <= 1'b1;
			end
			if (rdata.vld && better) begin
				found_q.best <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1 && !start) begin
			if (!rdata.vld && !found_q.free) begin
				free_slot_q <= raddr_s1;
			end
			if (rdata.vld && rdata.id == key) begin
				match_slot_q  <= raddr_s1;
				match_entry_q <= rdata;
			end
			if (rdata.vld && better) begin
				best_slot_q  <= raddr_s1;
				best_entry_q <= rdata;
			end
		end
	end

	assign found       = found_q;
	assign free_slot   = free_slot_q;
	assign match_slot  = match_slot_q;
	assign match_entry = match_entry_q;
	assign best_slot   = best_slot_q;
	assign best_entry  = best_entry_q;

endmodule

// File: rtl/indexed_priority_table_core.sv
// Indexed priority table: command sequencer, entry memory and scan unit.
// Depends on ipt_pkg, ipt_ram, ipt_scan and indexed_priority_table_core_macros.svh.
//
//  channel | signals                                                                 | dir
//  in      | in_valid in_ready cmd item_id payload                                   | in
//  out     | out_valid out_ready status result_id result_payload result_priority present | out
//
// Transactions are accepted one at a time: one read of the single entry RAM port per slot,
// then a drain state, a decide/write-back state, a result load and the idle state that
// accepts the next transaction.
// After reset a clearing pass writes every slot before in_ready rises.
// A waiting result does not block acceptance; a finished command holds until the
// output register is free.
`include "indexed_priority_table_core_macros.svh"

module indexed_priority_table_core import ipt_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [31:0] item_id,
	input  logic [31:0] payload,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] result_id,
	output logic [31:0] result_payload,
	output logic [15:0] result_priority,
	output logic        present
);

	localparam int AW = $clog2(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_RESP} state_t;

	state_t state_q;
	logic [AW-1:0] cnt_q;
	logic [2:0]  cmd_q;
	logic [31:0] id_q, pay_q, idc_q;
	logic        rvld_s1;
	logic [AW-1:0] raddr_s1;
	logic [2:0]  res_status_q;
	logic [31:0] res_id_q, res_pay_q;
	logic [15:0] res_prio_q;
	logic        res_pres_q;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [31:0] out_id_q, out_pay_q;
	logic [15:0] out_prio_q;
	logic        out_pres_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	ipt_entry_t    ram_wdata, ram_rdata;

	ipt_found_t    found;
	logic [AW-1:0] free_slot, match_slot, best_slot;
	ipt_entry_t    match_entry, best_entry;

	logic          dec_we, dec_inc;
	logic [AW-1:0] dec_addr;
	ipt_entry_t    dec_wdata;
	logic [2:0]    d_status;
	logic [31:0]   d_id, d_pay;
	logic [15:0]   d_prio, promo_prio;
	logic          d_pres;
	logic          accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	ipt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	ipt_scan #(.AW(AW)) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (accept),
		.rvld_s1     (rvld_s1),
		.raddr_s1    (raddr_s1),
		.rdata       (ram_rdata),
		.key         (id_q),
		.found       (found),
		.free_slot   (free_slot),
		.match_slot  (match_slot),
		.match_entry (match_entry),
		.best_slot   (best_slot),
		.best_entry  (best_entry)
	);

	assign promo_prio = (match_entry.prio == MAX_PRIO) ? MAX_PRIO : match_entry.prio + 16'd1;

	always_comb begin
		dec_we    = 1'b0;
		dec_inc   = 1'b0;
		dec_addr  = '0;
		dec_wdata = '0;
		d_status  = STAT_OK;
		d_id      = '0;
		d_pay     = '0;
		d_prio    = '0;
		d_pres    = 1'b0;
		unique case (cmd_q)
			CMD_ADD: begin
				if (idc_q == LAST_ID) begin
					d_status = STAT_EXHAUSTED;
				end else if (!found.free) begin
					d_status = STAT_FULL;
				end else begin
					dec_we    = 1'b1;
					dec_inc   = 1'b1;
					dec_addr  = free_slot;
					dec_wdata = '{vld: 1'b1, id: idc_q, prio: 16'd0, pay: pay_q};
					d_id      = idc_q;
					d_pres    = 1'b1;
				end
			end
			CMD_PROMOTE: begin
				d_id = id_q;
				if (!found.match) begin
					d_status = STAT_UNKNOWN;
				end else begin
					dec_we         = 1'b1;
					dec_addr       = match_slot;
					dec_wdata      = match_entry;
					dec_wdata.prio = promo_prio;
					d_prio         = promo_prio;
					d_pres         = 1'b1;
				end
			end
			CMD_IS_VALID: begin
				d_id   = id_q;
				d_pres = found.match;
			end
			CMD_GET: begin
				d_id = id_q;
				if (!found.match) begin
					d_status = STAT_UNKNOWN;
				end else begin
					d_pay  = match_entry.pay;
					d_prio = match_entry.prio;
					d_pres = 1'b1;
				end
			end
			CMD_GET_MAX, CMD_POP_MAX: begin
				if (!found.best) begin
					d_status = STAT_EMPTY;
				end else begin
					d_id   = best_entry.id;
					d_pay  = best_entry.pay;
					d_prio = best_entry.prio;
					d_pres = 1'b1;
					if (cmd_q == CMD_POP_MAX) begin
						dec_we        = 1'b1;
						dec_addr      = best_slot;
						dec_wdata     = best_entry;
						dec_wdata.vld = 1'b0;
					end
				end
			end
			default: begin
				d_status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (state_q == S_DECIDE) begin
			ram_we    = dec_we;
			ram_waddr = dec_addr;
			ram_wdata = dec_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			idc_q       <= '0;
			rvld_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvld_s1 <= (state_q == S_SCAN);
			if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cnt_q == LAST_SLOT) begin
						cnt_q   <= '0;
						state_q <= S_DRAIN;
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (dec_inc) begin
						idc_q <= idc_q + 32'd1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		raddr_s1 <= cnt_q;
		if (accept) begin
			cmd_q <= cmd;
			id_q  <= item_id;
			pay_q <= payload;
		end
		if (state_q == S_DECIDE) begin
			res_status_q <= d_status;
			res_id_q     <= d_id;
			res_pay_q    <= d_pay;
			res_prio_q   <= d_prio;
			res_pres_q   <= d_pres;
		end
		if (state_q == S_RESP && (!out_valid_q || out_ready)) begin
			out_status_q <= res_status_q;
			out_id_q     <= res_id_q;
			out_pay_q    <= res_pay_q;
			out_prio_q   <= res_prio_q;
			out_pres_q   <= res_pres_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign result_id       = out_id_q;
	assign result_payload  = out_pay_q;
	assign result_priority = out_prio_q;
	assign present         = out_pres_q;

	`IPT_ASSERT_NEXT(a_accept_starts_scan, accept, state_q == S_SCAN && cnt_q == '0)
	`IPT_ASSERT_NEXT(a_add_consumes_id, state_q == S_DECIDE && dec_inc, idc_q == $past(idc_q) + 32'd1)
	`IPT_ASSERT_NOW(a_no_write_on_query, state_q == S_DECIDE && ram_we, cmd_q == CMD_ADD || cmd_q == CMD_PROMOTE || cmd_q == CMD_POP_MAX)

endmodule
